// ===== hdl/gpt_pkg.sv =====
// Package for the gait phase tracker: widths, codes, constants and the
// command structs of the serial multiply and divide units. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gpt_pkg;

   localparam int TimeW   = 32;
   localparam int SmpW    = 16;
   localparam int LevelW  = 15;
   localparam int LimitW  = 16;
   localparam int StepW   = 16;
   localparam int CadW    = 15;
   localparam int StrideW = 15;
   localparam int DsW     = 13;
   localparam int ShufW   = 10;
   localparam int InW     = 80;
   localparam int OutW    = 72;
   localparam int CsrIdxW = 3;
   localparam int CsrW    = 16;

   localparam int McandW  = 32;
   localparam int MplierW = 15;
   localparam int ProdW   = McandW + MplierW;
   localparam int MulCntW = 4;
   localparam int NumW    = 48;
   localparam int DenW    = 16;
   localparam int QuoW    = 15;
   localparam int DivCntW = 6;

   localparam logic [1:0] PH_SWING = 2'd0;
   localparam logic [1:0] PH_HEEL  = 2'd1;
   localparam logic [1:0] PH_MID   = 2'd2;
   localparam logic [1:0] PH_TOE   = 2'd3;

   localparam logic [CsrIdxW-1:0] CSR_HS_LEVEL  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_STANCE    = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_SWING     = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_TOE_RATE  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_MAX_STEP  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_SHUF_LIM  = 3'd5;

   localparam logic [MulCntW-1:0] MUL_ITERS = 4'd15;
   localparam logic [NumW-1:0]    CAD_NUM   = 48'd600000 << 28;
   localparam logic [DivCntW-1:0] CAD_ITERS = 6'd20;
   localparam logic [MplierW-1:0] STR_MULT  = 15'd207;
   localparam logic [DenW-1:0]    STR_DIV   = 16'd400;
   localparam logic [DivCntW-1:0] STR_ITERS = 6'd23;
   localparam logic [DivCntW-1:0] DS_ITERS  = 6'd47;
   localparam logic [MplierW-1:0] DS_FIX_MULT = 15'd50;
   localparam logic [5:0]         DS_CAD_DIV  = 6'd60;
   localparam logic [5:0]         DS_FIX_DIV  = 6'd3;
   localparam logic [QuoW-1:0]    CAD_MAX   = 15'd32767;
   localparam logic [QuoW-1:0]    DS_CAP    = 15'd8000;
   localparam logic [SmpW:0]      ONE_G     = 17'd1024;
   localparam logic [ShufW:0]     SHUF_UP   = 11'd50;
   localparam logic [ShufW-1:0]   SHUF_DOWN = 10'd20;
   localparam logic [ShufW:0]     SHUF_MAX  = 11'd1000;

   typedef struct packed {
      logic               start;
      logic [McandW-1:0]  mcand;
      logic [MplierW-1:0] mplier;
   } mul_cmd_type;

   typedef struct packed {
      logic               start;
      logic [NumW-1:0]    num;
      logic [DenW-1:0]    den;
      logic [DivCntW-1:0] iters;
      logic [QuoW-1:0]    cap;
   } div_cmd_type;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_DIV_CAD = 7'b0000010,
      ST_MUL_STR = 7'b0000100,
      ST_DIV_STR = 7'b0001000,
      ST_MUL_DS  = 7'b0010000,
      ST_DIV_DS  = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/gpt_serial_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on gpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gpt_serial_mul
   import gpt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mul_cmd_type       cmd,
   output logic                   done,
   output logic [ProdW-1:0]       product
);

   logic               busy_ff;
   logic               done_ff;
   logic [MulCntW-1:0] cnt_ff;
   logic [ProdW-1:0]   acc_ff, acc_in;
   logic [ProdW-1:0]   mcand_ff;
   logic [MplierW-1:0] mplier_ff;

   assign acc_in = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !cmd.start && (cnt_ff == MulCntW'(1));
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= MUL_ITERS;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == MulCntW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff    <= '0;
         mcand_ff  <= {{MplierW{1'b0}}, cmd.mcand};
         mplier_ff <= cmd.mplier;
      end else if (busy_ff) begin
         acc_ff    <= acc_in;
         mcand_ff  <= {mcand_ff[ProdW-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[MplierW-1:1]};
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
`default_nettype wire

// ===== hdl/gpt_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient saturated to a cap.
// Numerator arrives left-aligned. Depends on gpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gpt_serial_div
   import gpt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire div_cmd_type       cmd,
   output logic                   done,
   output logic [QuoW-1:0]        quotient
);

   logic               busy_ff;
   logic               done_ff;
   logic [DivCntW-1:0] cnt_ff;
   logic [NumW-1:0]    num_ff;
   logic [DenW-1:0]    den_ff;
   logic [DenW-1:0]    rem_ff, rem_in;
   logic [QuoW-1:0]    quo_ff;
   logic [QuoW-1:0]    cap_ff;
   logic               ovf_ff;
   logic [DenW:0]      shifted;
   logic [DenW:0]      diff;
   logic               fits;

   assign shifted = {rem_ff, num_ff[NumW-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};
   assign rem_in  = fits ? diff[DenW-1:0] : shifted[DenW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !cmd.start && (cnt_ff == DivCntW'(1));
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.iters;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DivCntW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         num_ff <= cmd.num;
         den_ff <= cmd.den;
         cap_ff <= cmd.cap;
         rem_ff <= '0;
         quo_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NumW-2:0], 1'b0};
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[QuoW-2:0], fits};
         ovf_ff <= ovf_ff | quo_ff[QuoW-1];
      end
   end

   assign done     = done_ff;
   assign quotient = (ovf_ff || quo_ff > cap_ff) ? cap_ff : quo_ff;

endmodule
`default_nettype wire

// ===== hdl/gait_phase_tracker.sv =====
// Gait phase tracker top level: phase machine, metric registers, sequencer.
// Plain samples go straight to the result; a heel strike that updates cadence runs a
// 20-step cadence divide, a 15-step multiply and a 23-step stride divide; toe off runs
// a 15-step multiply and a 47-step divide. One sample is in work at a time.
// The result register lets the next beat be accepted while a result waits.
// Synchronous reset restores all thresholds and clears phase, counts and metrics.
`timescale 1ns / 1ps
`default_nettype none
module gait_phase_tracker
   import gpt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   // time_ms, vertical_accel, sagittal_rate, accel_magnitude
   input  wire logic [InW-1:0]     req_tdata,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   // phase, step_total, cadence_deci_spm, stride_mm, double_support_cpct,
   // shuffle_permille, one zero pad bit
   output logic [OutW-1:0]         rsp_tdata,
   input  wire logic               csr_we,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [CsrW-1:0]    csr_wdata
);

   logic [LevelW-1:0] hs_level_ff, band_ff, swing_level_ff, toe_rate_ff;
   logic [LimitW-1:0] max_step_ff, shuf_lim_ff;

   state_type          state_ff;
   logic [1:0]         phase_ff, phase_in;
   logic [TimeW-1:0]   last_ff;
   logic               seen_ff;
   logic [StepW-1:0]   steps_ff;
   logic [CadW-1:0]    cad_ff;
   logic [StrideW-1:0] stride_ff;
   logic [DsW-1:0]     ds_ff;
   logic [ShufW-1:0]   shuf_ff, shuf_in;
   logic [5:0]         ds_den_ff;
   logic               rsp_valid_ff;
   logic [OutW-1:0]    rsp_data_ff;

   logic [TimeW-1:0]  t_smp;
   logic [SmpW-1:0]   az, gy, mag;
   logic [SmpW-1:0]   az_abs, gy_abs, dev_abs;
   logic [SmpW:0]     dev;
   logic [TimeW-1:0]  dt;
   logic              accept;
   logic              strike, upd, stance, toe, to_swing;
   logic              out_free;
   logic [ShufW:0]    shuf_up;

   mul_cmd_type       mul_cmd;
   div_cmd_type       div_cmd;
   logic              mul_done, div_done;
   logic [ProdW-1:0]  mul_p;
   logic [QuoW-1:0]   div_q;

   gpt_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .done    (mul_done),
      .product (mul_p)
   );

   gpt_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_q)
   );

   assign t_smp   = req_tdata[31:0];
   assign az      = req_tdata[47:32];
   assign gy      = req_tdata[63:48];
   assign mag     = req_tdata[79:64];
   assign az_abs  = az[SmpW-1] ? ~az + 1'b1 : az;
   assign gy_abs  = gy[SmpW-1] ? ~gy + 1'b1 : gy;
   assign dev     = {1'b0, mag} - ONE_G;
   assign dev_abs = dev[SmpW] ? SmpW'(~dev + 1'b1) : dev[SmpW-1:0];
   assign dt      = t_smp - last_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign strike   = (phase_ff == PH_SWING) && (az_abs > {1'b0, hs_level_ff});
   assign upd      = strike && seen_ff && (dt < {16'b0, max_step_ff});
   assign stance   = (phase_ff == PH_HEEL) && (dev_abs < {1'b0, band_ff});
   assign toe      = (phase_ff == PH_MID) && (gy_abs > {1'b0, toe_rate_ff});
   assign to_swing = (phase_ff == PH_TOE) && (mag < {1'b0, swing_level_ff});

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_SWING: if (strike) phase_in = PH_HEEL;
         PH_HEEL:  if (stance) phase_in = PH_MID;
         PH_MID:   if (toe) phase_in = PH_TOE;
         PH_TOE:   if (to_swing) phase_in = PH_SWING;
         default:  phase_in = phase_ff;
      endcase
   end

   always_comb begin
      mul_cmd = '0;
      if (state_ff == ST_IDLE && accept && toe) begin
         mul_cmd.start  = 1'b1;
         mul_cmd.mcand  = dt;
         mul_cmd.mplier = (cad_ff != '0) ? cad_ff : DS_FIX_MULT;
      end else if (state_ff == ST_DIV_CAD && div_done) begin
         mul_cmd.start  = 1'b1;
         mul_cmd.mcand  = {{(McandW-QuoW){1'b0}}, div_q};
         mul_cmd.mplier = STR_MULT;
      end
   end

   always_comb begin
      div_cmd = '0;
      if (state_ff == ST_IDLE && accept && upd) begin
         div_cmd.start = 1'b1;
         div_cmd.num   = CAD_NUM;
         div_cmd.den   = dt[DenW-1:0];
         div_cmd.iters = CAD_ITERS;
         div_cmd.cap   = CAD_MAX;
      end else if (state_ff == ST_MUL_STR && mul_done) begin
         div_cmd.start = 1'b1;
         div_cmd.num   = {mul_p[22:0], 25'b0};
         div_cmd.den   = STR_DIV;
         div_cmd.iters = STR_ITERS;
         div_cmd.cap   = CAD_MAX;
      end else if (state_ff == ST_MUL_DS && mul_done) begin
         div_cmd.start = 1'b1;
         div_cmd.num   = {mul_p, 1'b0};
         div_cmd.den   = {10'b0, ds_den_ff};
         div_cmd.iters = DS_ITERS;
         div_cmd.cap   = DS_CAP;
      end
   end

   assign shuf_up = {1'b0, shuf_ff} + SHUF_UP;
   always_comb begin
      if (stride_ff != '0 && {1'b0, stride_ff} < shuf_lim_ff) begin
         shuf_in = (shuf_up > SHUF_MAX) ? SHUF_MAX[ShufW-1:0] : shuf_up[ShufW-1:0];
      end else begin
         shuf_in = (shuf_ff > SHUF_DOWN) ? shuf_ff - SHUF_DOWN : '0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_level_ff    <= 15'd1638;
         band_ff        <= 15'd410;
         swing_level_ff <= 15'd717;
         toe_rate_ff    <= 15'd2400;
         max_step_ff    <= 16'd3000;
         shuf_lim_ff    <= 16'd300;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HS_LEVEL: hs_level_ff    <= csr_wdata[LevelW-1:0];
            CSR_STANCE:   band_ff        <= csr_wdata[LevelW-1:0];
            CSR_SWING:    swing_level_ff <= csr_wdata[LevelW-1:0];
            CSR_TOE_RATE: toe_rate_ff    <= csr_wdata[LevelW-1:0];
            CSR_MAX_STEP: max_step_ff    <= csr_wdata;
            CSR_SHUF_LIM: shuf_lim_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_SWING;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         steps_ff     <= '0;
         cad_ff       <= '0;
         stride_ff    <= '0;
         ds_ff        <= '0;
         shuf_ff      <= '0;
         ds_den_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  phase_ff <= phase_in;
                  if (strike) begin
                     last_ff  <= t_smp;
                     seen_ff  <= 1'b1;
                     steps_ff <= steps_ff + 1'b1;
                  end
                  ds_den_ff <= (cad_ff != '0) ? DS_CAD_DIV : DS_FIX_DIV;
                  if (upd)      state_ff <= ST_DIV_CAD;
                  else if (toe) state_ff <= ST_MUL_DS;
                  else          state_ff <= ST_DONE;
               end
            end
            ST_DIV_CAD: begin
               if (div_done) begin
                  cad_ff   <= div_q;
                  state_ff <= ST_MUL_STR;
               end
            end
            ST_MUL_STR: if (mul_done) state_ff <= ST_DIV_STR;
            ST_DIV_STR: begin
               if (div_done) begin
                  stride_ff <= div_q;
                  state_ff  <= ST_DONE;
               end
            end
            ST_MUL_DS: if (mul_done) state_ff <= ST_DIV_DS;
            ST_DIV_DS: begin
               if (div_done) begin
                  ds_ff    <= div_q[DsW-1:0];
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  shuf_ff  <= shuf_in;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff <= {1'b0, shuf_in, ds_ff, stride_ff, cad_ff, steps_ff, phase_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for gait_phase_tracker: a directed table of samples, then phased random gait
// sequences under several threshold settings and handshake pressures, checked beat by beat.
// Depends on gpt_pkg and the gait_phase_tracker RTL.
module testbench;
   import gpt_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 9;
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 100;
   localparam int NUM_REGS      = 6;
   localparam int NUM_PHASES    = 7;
   localparam logic [CsrIdxW-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CsrIdxW-1:0] CSR_SPARE_B = 3'd7;
   localparam logic [CsrIdxW-1:0] WRITE_ORDER [NUM_REGS+2] = '{
      CSR_HS_LEVEL, CSR_STANCE, CSR_SWING, CSR_TOE_RATE, CSR_MAX_STEP, CSR_SHUF_LIM,
      CSR_SPARE_A, CSR_SPARE_B};

   typedef struct packed {
      logic [TimeW-1:0]        t;
      logic signed [SmpW-1:0]  az;
      logic signed [SmpW-1:0]  gy;
      logic [SmpW-1:0]         mag;
   } gait_sample_type;

   typedef struct packed {
      logic [1:0]          phase;
      logic [StepW-1:0]    steps;
      logic [CadW-1:0]     cadence;
      logic [StrideW-1:0]  stride;
      logic [DsW-1:0]      dsupport;
      logic [ShufW-1:0]    shuffle;
   } gait_metrics_type;

   typedef struct packed {
      gait_sample_type  smp;
      logic             typed;
      gait_metrics_type want;
   } stim_row_type;

   localparam gait_metrics_type NO_WANT = '0;

   localparam stim_row_type GAIT_SCRIPT [26] = '{
      '{'{32'd0, 16'sd0, 16'sd0, 16'd0}, 1'b1,
        '{PH_SWING, 16'd0, 15'd0, 15'd0, 13'd0, 10'd0}},
      '{'{32'd1000, 16'h8000, 16'sd0, 16'd0}, 1'b1,
        '{PH_HEEL, 16'd1, 15'd0, 15'd0, 13'd0, 10'd0}},
      '{'{32'd1100, 16'sd0, 16'sd0, 16'd1024}, 1'b1,
        '{PH_MID, 16'd1, 15'd0, 15'd0, 13'd0, 10'd0}},
      '{'{32'd1300, 16'sd0, 16'sd32767, 16'd0}, 1'b1,
        '{PH_TOE, 16'd1, 15'd0, 15'd0, 13'd5000, 10'd0}},
      '{'{32'd1400, 16'sd0, 16'sd0, 16'd0}, 1'b1,
        '{PH_SWING, 16'd1, 15'd0, 15'd0, 13'd5000, 10'd0}},
      '{'{32'd2000, 16'sd32767, 16'sd0, 16'd0}, 1'b0, NO_WANT},
      '{'{32'd2100, 16'sd0, 16'sd0, 16'd1433}, 1'b0, NO_WANT},
      '{'{32'd2000, 16'sd0, 16'h8000, 16'd0}, 1'b0, NO_WANT},
      '{'{32'd2200, 16'sd0, 16'sd0, 16'd717}, 1'b0, NO_WANT},
      '{'{32'd2200, 16'sd0, 16'sd0, 16'd716}, 1'b0, NO_WANT},
      '{'{32'd2300, 16'sd1638, 16'sd0, 16'd0}, 1'b0, NO_WANT},
      // zero strike interval saturates cadence
      '{'{32'd2000, -16'sd1639, 16'sd0, 16'd0}, 1'b1,
        '{PH_HEEL, 16'd3, 15'd32767, 15'd16956, 13'd0, 10'd0}},
      '{'{32'd2000, 16'sd0, 16'sd0, 16'd614}, 1'b0, NO_WANT},
      '{'{32'd2000, 16'sd0, 16'sd0, 16'd615}, 1'b0, NO_WANT},
      '{'{32'd2500, 16'sd0, 16'sd2400, 16'd0}, 1'b0, NO_WANT},
      '{'{32'd1002000, 16'sd0, 16'sd2401, 16'd0}, 1'b1,
        '{PH_TOE, 16'd3, 15'd32767, 15'd16956, 13'd8000, 10'd0}},
      '{'{32'd1002000, 16'sd0, 16'sd0, 16'd0}, 1'b0, NO_WANT},
      '{'{32'd5000, 16'sd2000, 16'sd0, 16'd0}, 1'b0, NO_WANT},
      '{'{32'd5000, 16'sd0, 16'sd0, 16'd1024}, 1'b0, NO_WANT},
      '{'{32'd5001, 16'sd0, -16'sd3000, 16'd0}, 1'b0, NO_WANT},
      '{'{32'd5001, 16'sd0, 16'sd0, 16'd0}, 1'b0, NO_WANT},
      '{'{32'hFFFF_FF00, 16'sd2000, 16'sd0, 16'd0}, 1'b0, NO_WANT},
      '{'{32'hFFFF_FF00, 16'sd0, 16'sd0, 16'd1024}, 1'b0, NO_WANT},
      '{'{32'hFFFF_FF80, 16'sd0, 16'sd3000, 16'd0}, 1'b0, NO_WANT},
      '{'{32'hFFFF_FF80, 16'sd0, 16'sd0, 16'd0}, 1'b0, NO_WANT},
      // strike interval across the timestamp wrap
      '{'{32'h0000_0100, -16'sd2000, 16'sd0, 16'd0}, 1'b0, NO_WANT}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [InW-1:0]     req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [OutW-1:0]    rsp_tdata;
   logic               csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrW-1:0]    csr_wdata = '0;

   // thresholds as the block should hold them
   logic [LevelW-1:0]  hs_level      = 15'd1638;
   logic [LevelW-1:0]  stance_band   = 15'd410;
   logic [LevelW-1:0]  swing_level   = 15'd717;
   logic [LevelW-1:0]  toe_rate      = 15'd2400;
   logic [LimitW-1:0]  step_window   = 16'd3000;
   logic [LimitW-1:0]  shuffle_limit = 16'd300;

   // gait state as the block should hold it
   logic [1:0]         phase_m       = PH_SWING;
   logic [TimeW-1:0]   last_strike_m = '0;
   logic               strike_seen_m = 1'b0;
   logic [StepW-1:0]   steps_m       = '0;
   logic [CadW-1:0]    cadence_m     = '0;
   logic [StrideW-1:0] stride_m      = '0;
   logic [DsW-1:0]     dsupport_m    = '0;
   logic [ShufW-1:0]   shuffle_m     = '0;

   gait_metrics_type   pending_metrics [$];
   logic [TimeW-1:0]   stamp_ms = '0;
   int                 mismatches = 0;
   int                 stall_pct = 0;
   int                 hold_req = 0;
   int                 hold_ack = 0;
   int                 hold_left = 0;
   int                 quiet = 0;

   gait_phase_tracker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic int abs_of(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // signed sample whose magnitude is strictly above level
   function automatic logic [SmpW-1:0] beyond(input logic [LevelW-1:0] level);
      int m;
      if ($urandom_range(2) == 0) m = int'(level) + 1;
      else m = int'($urandom_range(32768, int'(level) + 1));
      return ($urandom_range(1) != 0) ? SmpW'(m) : SmpW'(-m);
   endfunction

   function automatic gait_metrics_type advance_gait(input gait_sample_type s);
      int                az_v;
      int                gy_v;
      int                mag_v;
      int                shuf_v;
      logic [TimeW-1:0]  gap;
      longint unsigned   cad;
      longint unsigned   ds;
      gait_metrics_type  r;
      az_v  = $signed(s.az);
      gy_v  = $signed(s.gy);
      mag_v = int'(s.mag);
      gap   = s.t - last_strike_m;
      case (phase_m)
         PH_SWING: begin
            if (abs_of(az_v) > int'(hs_level)) begin
               phase_m = PH_HEEL;
               if (strike_seen_m && gap < step_window) begin
                  cad = (gap == '0) ? 64'(CAD_MAX) : 64'd600000 / 64'(gap);
                  if (cad > 64'(CAD_MAX)) cad = 64'(CAD_MAX);
                  cadence_m = CadW'(cad);
                  stride_m  = StrideW'(cad * 64'd5175 / 64'd10000);
               end
               last_strike_m = s.t;
               strike_seen_m = 1'b1;
               steps_m       = steps_m + 1'b1;
            end
         end
         PH_HEEL: begin
            if (abs_of(mag_v - int'(ONE_G)) < int'(stance_band)) phase_m = PH_MID;
         end
         PH_MID: begin
            if (abs_of(gy_v) > int'(toe_rate)) begin
               ds = (cadence_m != '0) ? 64'(gap) * 64'(cadence_m) / 64'd60
                                      : 64'(gap) * 64'd100 / 64'd6;
               dsupport_m = (ds > 64'(DS_CAP)) ? DsW'(DS_CAP) : DsW'(ds);
               phase_m    = PH_TOE;
            end
         end
         default: begin
            if (mag_v < int'(swing_level)) phase_m = PH_SWING;
         end
      endcase
      shuf_v = int'(shuffle_m);
      if (stride_m != '0 && stride_m < shuffle_limit) begin
         shuf_v = shuf_v + int'(SHUF_UP);
         if (shuf_v > int'(SHUF_MAX)) shuf_v = int'(SHUF_MAX);
      end else begin
         shuf_v = (shuf_v > int'(SHUF_DOWN)) ? shuf_v - int'(SHUF_DOWN) : 0;
      end
      shuffle_m = ShufW'(shuf_v);
      r = '{phase_m, steps_m, cadence_m, stride_m, dsupport_m, shuffle_m};
      return r;
   endfunction

   task automatic send_beat(input gait_sample_type s, input logic typed,
                            input gait_metrics_type want, input int idle_pct);
      int               gap_cycles;
      gait_metrics_type predicted;
      gap_cycles = 0;
      while (int'($urandom_range(99)) < idle_pct) gap_cycles++;
      if (gap_cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_cycles) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {s.mag, s.gy, s.az, s.t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = advance_gait(s);
      pending_metrics.push_back(typed ? want : predicted);
   endtask

   task automatic drain_results(input int extra);
      req_tvalid <= 1'b0;
      while (pending_metrics.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_settings(input logic [NUM_REGS-1:0][CsrW-1:0] vals);
      logic [CsrW-1:0] data;
      for (int i = 0; i < NUM_REGS + 2; i++) begin
         if (i < NUM_REGS) data = vals[i];
         else data = CsrW'($urandom);
         csr_we    <= 1'b1;
         csr_index <= WRITE_ORDER[i];
         csr_wdata <= data;
         case (WRITE_ORDER[i])
            CSR_HS_LEVEL: hs_level      = data[LevelW-1:0];
            CSR_STANCE:   stance_band   = data[LevelW-1:0];
            CSR_SWING:    swing_level   = data[LevelW-1:0];
            CSR_TOE_RATE: toe_rate      = data[LevelW-1:0];
            CSR_MAX_STEP: step_window   = data[LimitW-1:0];
            CSR_SHUF_LIM: shuffle_limit = data[LimitW-1:0];
            default: ;
         endcase
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      gait_metrics_type want;
      gait_metrics_type got;
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_ack != hold_req) begin
         hold_ack   <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (int'($urandom_range(99)) >= stall_pct);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.phase    = rsp_tdata[1:0];
         got.steps    = rsp_tdata[17:2];
         got.cadence  = rsp_tdata[32:18];
         got.stride   = rsp_tdata[47:33];
         got.dsupport = rsp_tdata[60:48];
         got.shuffle  = rsp_tdata[70:61];
         if (pending_metrics.size() == 0) begin
            $display("%0t ns: beat with nothing expected, got %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_metrics.pop_front();
            check_field("phase", int'(want.phase), int'(got.phase));
            check_field("step_total", int'(want.steps), int'(got.steps));
            check_field("cadence_deci_spm", int'(want.cadence), int'(got.cadence));
            check_field("stride_mm", int'(want.stride), int'(got.stride));
            check_field("double_support_cpct", int'(want.dsupport), int'(got.dsupport));
            check_field("shuffle_permille", int'(want.shuffle), int'(got.shuffle));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("gait_phase_tracker: mismatch");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      logic [NUM_REGS-1:0][CsrW-1:0] regs;
      gait_sample_type s;
      int items;
      int sender_pct;
      int pick;
      int off;
      int mag_v;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (GAIT_SCRIPT[i])
         send_beat(GAIT_SCRIPT[i].smp, GAIT_SCRIPT[i].typed, GAIT_SCRIPT[i].want, 0);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain_results(8);
         regs[CSR_HS_LEVEL] = CsrW'($urandom_range(4000, 100));
         regs[CSR_STANCE]   = CsrW'($urandom_range(2000, 50));
         regs[CSR_SWING]    = CsrW'($urandom_range(1500, 200));
         regs[CSR_TOE_RATE] = CsrW'($urandom_range(6000, 200));
         regs[CSR_MAX_STEP] = CsrW'($urandom_range(20000, 500));
         regs[CSR_SHUF_LIM] = CsrW'($urandom_range(1500, 1));
         sender_pct = 0;
         stall_pct  = 0;
         items      = 250;
         case (ph)
            0: begin
               regs  = {16'd300, 16'd3000, 16'd2400, 16'd717, 16'd410, 16'd1638};
               items = 200;
            end
            1: begin
               regs       = {16'd400, 16'd20000, 16'd2000, 16'd800, 16'd600, 16'd1200};
               sender_pct = 46;
            end
            2: begin
               regs      = {NUM_REGS{16'hFFFF}};
               stall_pct = 46;
               items     = 180;
            end
            3: begin
               sender_pct = 14;
               stall_pct  = 14;
            end
            4: begin
               regs  = '0;
               items = 60;
            end
            5: begin
               regs[CSR_MAX_STEP] = 16'hFFFF;
               regs[CSR_SHUF_LIM] = 16'hFFFF;
               items = 200;
            end
            default: begin
               regs[CSR_MAX_STEP] = 16'd1;
               stall_pct = 46;
            end
         endcase
         write_settings(regs);
         stamp_ms = $urandom;
         // receiver holds off while samples keep coming
         if (ph == 5) hold_req++;

         repeat (items) begin
            pick = $urandom_range(99);
            if (pick < 5) stamp_ms = $urandom;
            else if (pick < 15) stamp_ms = stamp_ms + $urandom_range(30);
            else stamp_ms = stamp_ms + $urandom_range(int'(step_window) / 4 + 20);
            s.t   = stamp_ms;
            s.az  = SmpW'($urandom);
            s.gy  = SmpW'($urandom);
            s.mag = SmpW'($urandom);
            pick  = $urandom_range(99);
            if (pick < 75) begin
               case (phase_m)
                  PH_SWING: s.az = beyond(hs_level);
                  PH_HEEL: begin
                     if (stance_band != '0) begin
                        off   = int'($urandom_range(int'(stance_band) - 1));
                        mag_v = ($urandom_range(1) != 0) ? int'(ONE_G) + off
                                                         : int'(ONE_G) - off;
                        if (mag_v < 0) mag_v = int'(ONE_G) + off;
                        s.mag = SmpW'(mag_v);
                     end
                  end
                  PH_MID: s.gy = beyond(toe_rate);
                  default: begin
                     if (swing_level != '0)
                        s.mag = SmpW'($urandom_range(int'(swing_level) - 1));
                  end
               endcase
            end else if (pick < 88) begin
               // values on the thresholds
               off  = int'(hs_level) + int'($urandom_range(1));
               s.az = SmpW'(($urandom_range(1) != 0) ? off : -off);
               off  = int'(toe_rate) + int'($urandom_range(1));
               s.gy = SmpW'(($urandom_range(1) != 0) ? off : -off);
               case ($urandom_range(3))
                  0: mag_v = int'(ONE_G) - int'(stance_band) + int'($urandom_range(1));
                  1: mag_v = int'(ONE_G) + int'(stance_band) - int'($urandom_range(1));
                  default: mag_v = int'(swing_level) - int'($urandom_range(1));
               endcase
               s.mag = (mag_v < 0) ? '0 : SmpW'(mag_v);
            end
            send_beat(s, 1'b0, NO_WANT, sender_pct);
         end
      end

      drain_results(SETTLE_CYCLES);
      if (mismatches == 0) begin
         $display("gait_phase_tracker: match");
      end else begin
         $display("gait_phase_tracker: mismatch");
      end
      $finish;
   end

endmodule
